/* design/miss_status_holding_registers_top_defines.svh */
// assertion macros shared by the miss table
`ifndef MISS_STATUS_HOLDING_REGISTERS_TOP_DEFINES_SVH
`define MISS_STATUS_HOLDING_REGISTERS_TOP_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define MSHR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence that must hold in the same cycle as its antecedent
`define MSHR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

/* design/mshr_pkg.sv */
package mshr_pkg;

  // table geometry
  localparam int unsigned ENTRIES    = 8;
  localparam int unsigned LINE_WORDS = 16;
  localparam int unsigned LINE_BYTES = LINE_WORDS * 4;
  localparam int unsigned IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned WORD_W     = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int unsigned WCNT_W     = $clog2(LINE_WORDS + 1);
  localparam int unsigned MEM_DEPTH  = ENTRIES * LINE_WORDS;
  localparam int unsigned MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // stream widths
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 112;

  typedef enum logic [2:0] {
    OP_FIND      = 3'd0,
    OP_MISS      = 3'd1,
    OP_ACCEPT    = 3'd2,
    OP_RESP      = 3'd3,
    OP_FILL_DONE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MERGE_RD,
    ST_MERGE_WR,
    ST_RESULT,
    ST_FILL_RD,
    ST_FILL_OUT
  } state_e;

  // one word of merged store data
  typedef struct packed {
    logic [3:0]  strobe;
    logic [31:0] data;
  } merge_t;

  // verdict of the shared entry comparator
  typedef struct packed {
    logic match;
    logic free;
  } cmp_t;

  // byte overlay of data onto base under a strobe
  function automatic logic [31:0] overlay(logic [31:0] base, logic [31:0] data,
                                          logic [3:0] strobe);
    logic [31:0] res;
    res = base;
    for (int i = 0; i < 4; i++) begin
      if (strobe[i]) res[8*i +: 8] = data[8*i +: 8];
    end
    return res;
  endfunction

endpackage

/* design/mshr_merge_ram.sv */
module mshr_merge_ram #(
  parameter int unsigned AW = 7,
  parameter int unsigned DW = 36
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/mshr_entry_cmp.sv */
module mshr_entry_cmp (
  input  logic        valid_i,
  input  logic [31:0] line_addr_i,
  input  logic [31:0] probe_line_i,
  output mshr_pkg::cmp_t res_o
);
  import mshr_pkg::*;

  // line match against a live entry, or a free slot
  always_comb begin
    res_o.match = valid_i && (line_addr_i == probe_line_i);
    res_o.free  = !valid_i;
  end

endmodule

/* design/miss_status_holding_registers_top.sv */
// Miss table for a data cache, one transaction at a time.
// s_axis carries requests: tuser is the operation (find, miss, bus accept,
// response word, fill done), tlast marks the last response word of a line.
// m_axis returns results: tuser flags a fill word, tlast marks the last result
// of a request. Every request gives one result, except a response word that
// completes a line, which gives LINE_WORDS fill words in order.
// Find and miss walk the entries one at a time through one comparator, then
// load the result; a store miss adds a read-modify-write of the merge memory
// before the result. Bus accept, response and fill done go straight to the
// result. A line fill reads each word through the registered read port of the
// merge memory and loads it before reading the next. s_axis_tready is high only while idle,
// so the next request is taken the cycle after the last result is loaded.
// A stalled receiver holds the result register and the sequencer waits on it.
// Reset clears all entries, counters and the hold buffer at once; the merge
// memory is tracked by per-word valid flops, so no clearing pass is needed.
`include "miss_status_holding_registers_top_defines.svh"

module miss_status_holding_registers_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // addr, has_store, store_data, store_strobe, entry_id, resp_word
  input  logic [mshr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [mshr_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // resp_last
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // free_count, lookup_hit, accepted, pend_valid, pend_line, req_id, fill_addr,
  // fill_dirty, fill_index, fill_word, one zero pad bit
  output logic [mshr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // fill_valid
  output logic                            m_axis_tuser,
  // last
  output logic                            m_axis_tlast
);
  import mshr_pkg::*;

  // input decode
  logic [31:0] in_addr, in_sdata, in_rword;
  logic        in_store;
  logic [3:0]  in_strb;
  logic [2:0]  in_id;
  op_e         in_op;
  assign in_addr  = s_axis_tdata[31:0];
  assign in_store = s_axis_tdata[32];
  assign in_sdata = s_axis_tdata[64:33];
  assign in_strb  = s_axis_tdata[68:65];
  assign in_id    = s_axis_tdata[71:69];
  assign in_rword = s_axis_tdata[103:72];
  assign in_op    = op_e'(s_axis_tuser);

  state_e state_q, state_d;

  // latched request
  op_e         op_q;
  logic [31:0] line_q, sdata_q;
  logic [WORD_W-1:0] word_q;
  logic        store_q;
  logic [3:0]  strb_q;

  // scan state
  logic [IDX_W-1:0] idx_q, match_idx_q, free_idx_q, slot_q;
  logic             match_found_q, free_found_q;
  logic             hit_q, acc_q;

  // entry table
  logic [ENTRIES-1:0]   entry_valid_q, entry_issued_q, entry_dirty_q;
  logic [31:0]          entry_line_q [ENTRIES];
  logic [MEM_DEPTH-1:0] word_valid_q;
  logic [CNT_W-1:0]     used_q;

  // hold buffer
  logic              hold_valid_q, collecting_q;
  logic [IDX_W-1:0]  hold_entry_q;
  logic [WCNT_W-1:0] wc_q, hold_cnt_q;
  logic [31:0]       hold_words_q [LINE_WORDS];
  logic [WORD_W-1:0] k_q;

  // result register
  logic                  out_valid_q, out_user_q, out_last_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  logic in_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // shared comparator
  cmp_t cmp;
  mshr_entry_cmp u_cmp (
    .valid_i     (entry_valid_q[idx_q]),
    .line_addr_i (entry_line_q[idx_q]),
    .probe_line_i(line_q),
    .res_o       (cmp)
  );

  logic             scan_done, fin_match, fin_free;
  logic [IDX_W-1:0] fin_match_idx, fin_free_idx;
  assign scan_done     = (idx_q == IDX_W'(ENTRIES - 1));
  assign fin_match     = match_found_q || cmp.match;
  assign fin_match_idx = match_found_q ? match_idx_q : idx_q;
  assign fin_free      = free_found_q || cmp.free;
  assign fin_free_idx  = free_found_q ? free_idx_q : idx_q;

  // request decisions at the input transaction
  logic [IDX_W-1:0]  id_idx;
  logic              id_ok, accept_ok, resp_ok, resp_emit, done_ok, idle_acc;
  logic [WCNT_W-1:0] wc_eff, wc_new;
  assign id_idx    = IDX_W'(in_id);
  assign id_ok     = (32'(in_id) < ENTRIES);
  assign accept_ok = id_ok && entry_valid_q[id_idx] && !entry_issued_q[id_idx];
  assign resp_ok   = !hold_valid_q && id_ok && entry_valid_q[id_idx] &&
                     entry_issued_q[id_idx] && (!collecting_q || hold_entry_q == id_idx);
  assign wc_eff    = collecting_q ? wc_q : '0;
  assign wc_new    = wc_eff + WCNT_W'(1);
  assign resp_emit = s_axis_tlast || (wc_new >= WCNT_W'(LINE_WORDS));
  assign done_ok   = hold_valid_q;
  assign idle_acc  = in_acc && (((in_op == OP_ACCEPT) && accept_ok) ||
                                ((in_op == OP_RESP) && resp_ok) ||
                                ((in_op == OP_FILL_DONE) && done_ok));

  // merge memory
  logic [MEM_AW-1:0] merge_addr, fill_addr;
  logic              ram_we, ram_re;
  logic [MEM_AW-1:0] ram_raddr;
  merge_t            ram_wdata, ram_rdata, merge_base, fill_merge;
  assign merge_addr = MEM_AW'(slot_q * LINE_WORDS + word_q);
  assign fill_addr  = MEM_AW'(hold_entry_q * LINE_WORDS + k_q);
  assign ram_re     = (state_q == ST_MERGE_RD) || (state_q == ST_FILL_RD);
  assign ram_raddr  = (state_q == ST_FILL_RD) ? fill_addr : merge_addr;
  assign ram_we     = (state_q == ST_MERGE_WR);
  assign merge_base = word_valid_q[merge_addr] ? ram_rdata : '0;
  assign fill_merge = word_valid_q[fill_addr] ? ram_rdata : '0;
  assign ram_wdata  = '{strobe: merge_base.strobe | strb_q,
                        data:   overlay(merge_base.data, sdata_q, strb_q)};

  mshr_merge_ram #(
    .AW(MEM_AW),
    .DW($bits(merge_t))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(merge_addr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // lowest valid entry not yet issued
  logic             pend_valid;
  logic [31:0]      pend_line;
  logic [IDX_W-1:0] req_id;
  always_comb begin
    pend_valid = 1'b0;
    pend_line  = '0;
    req_id     = '0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      if (entry_valid_q[e] && !entry_issued_q[e]) begin
        pend_valid = 1'b1;
        pend_line  = entry_line_q[e];
        req_id     = IDX_W'(e);
      end
    end
  end

  // result fields
  logic [3:0]  free_count;
  logic [31:0] fill_word, hold_word;
  assign free_count = 4'(ENTRIES) - 4'(used_q);
  assign hold_word  = (WCNT_W'(k_q) < hold_cnt_q) ? hold_words_q[k_q] : '0;
  assign fill_word  = overlay(hold_word, fill_merge.data, fill_merge.strobe);

  logic [OUT_DATA_W-1:0] res_data, fill_data;
  assign res_data  = {1'b0, 32'd0, 4'd0, 1'b0, 32'd0, 3'(req_id), pend_line,
                      pend_valid, acc_q, hit_q, free_count};
  assign fill_data = {1'b0, fill_word, 4'(k_q), entry_dirty_q[hold_entry_q],
                      entry_line_q[hold_entry_q], 3'(req_id), pend_line,
                      pend_valid, 1'b1, 1'b0, free_count};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_FIND, OP_MISS: state_d = ST_SCAN;
            OP_RESP:          state_d = (resp_ok && resp_emit) ? ST_FILL_RD : ST_RESULT;
            default:          state_d = ST_RESULT;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (op_q == OP_MISS && (fin_match || fin_free) && store_q) state_d = ST_MERGE_RD;
          else state_d = ST_RESULT;
        end
      end
      ST_MERGE_RD: state_d = ST_MERGE_WR;
      ST_MERGE_WR: state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_FILL_RD: state_d = ST_FILL_OUT;
      ST_FILL_OUT: begin
        if (out_free) state_d = (k_q == WORD_W'(LINE_WORDS - 1)) ? ST_IDLE : ST_FILL_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result loading
  logic                  load_res, load_fill;
  always_comb begin
    load_res  = (state_q == ST_RESULT) && out_free;
    load_fill = (state_q == ST_FILL_OUT) && out_free;
  end

  // sequencer and table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      idx_q          <= '0;
      match_idx_q    <= '0;
      free_idx_q     <= '0;
      slot_q         <= '0;
      match_found_q  <= 1'b0;
      free_found_q   <= 1'b0;
      hit_q          <= 1'b0;
      acc_q          <= 1'b0;
      entry_valid_q  <= '0;
      entry_issued_q <= '0;
      entry_dirty_q  <= '0;
      for (int e = 0; e < ENTRIES; e++) begin
        entry_line_q[e] <= '0;
      end
      word_valid_q   <= '0;
      used_q         <= '0;
      hold_valid_q   <= 1'b0;
      collecting_q   <= 1'b0;
      hold_entry_q   <= '0;
      wc_q           <= '0;
      hold_cnt_q     <= '0;
      for (int w = 0; w < LINE_WORDS; w++) begin
        hold_words_q[w] <= '0;
      end
      k_q            <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          idx_q         <= '0;
          match_found_q <= 1'b0;
          free_found_q  <= 1'b0;
          hit_q         <= 1'b0;
          acc_q         <= idle_acc;
          k_q           <= '0;
          if (in_acc) begin
            case (in_op)
              OP_ACCEPT: begin
                if (accept_ok) begin
                  entry_issued_q[id_idx] <= 1'b1;
                end
              end
              OP_RESP: begin
                if (resp_ok) begin
                  hold_entry_q                    <= id_idx;
                  hold_words_q[WORD_W'(wc_eff)]   <= in_rword;
                  if (resp_emit) begin
                    collecting_q <= 1'b0;
                    wc_q         <= '0;
                    hold_cnt_q   <= wc_new;
                    hold_valid_q <= 1'b1;
                  end else begin
                    collecting_q <= 1'b1;
                    wc_q         <= wc_new;
                  end
                end
              end
              OP_FILL_DONE: begin
                if (done_ok) begin
                  entry_valid_q[hold_entry_q]  <= 1'b0;
                  entry_issued_q[hold_entry_q] <= 1'b0;
                  entry_dirty_q[hold_entry_q]  <= 1'b0;
                  for (int w = 0; w < LINE_WORDS; w++) begin
                    word_valid_q[MEM_AW'(hold_entry_q * LINE_WORDS + w)] <= 1'b0;
                  end
                  if (used_q != '0) used_q <= used_q - CNT_W'(1);
                  hold_valid_q <= 1'b0;
                  hold_entry_q <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (!match_found_q && cmp.match) begin
            match_found_q <= 1'b1;
            match_idx_q   <= idx_q;
          end
          if (!free_found_q && cmp.free) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          idx_q <= idx_q + IDX_W'(1);
          if (scan_done) begin
            if (op_q == OP_FIND) begin
              hit_q <= fin_match;
              acc_q <= 1'b1;
            end else begin
              acc_q  <= fin_match || fin_free;
              slot_q <= fin_match ? fin_match_idx : fin_free_idx;
              if (!fin_match && fin_free) begin
                entry_valid_q[fin_free_idx]  <= 1'b1;
                entry_issued_q[fin_free_idx] <= 1'b0;
                entry_dirty_q[fin_free_idx]  <= 1'b0;
                entry_line_q[fin_free_idx]   <= line_q;
                for (int w = 0; w < LINE_WORDS; w++) begin
                  word_valid_q[MEM_AW'(fin_free_idx * LINE_WORDS + w)] <= 1'b0;
                end
                used_q <= used_q + CNT_W'(1);
              end
            end
          end
        end
        ST_MERGE_WR: begin
          word_valid_q[merge_addr] <= 1'b1;
          entry_dirty_q[slot_q]    <= 1'b1;
        end
        ST_FILL_OUT: begin
          if (out_free) k_q <= k_q + WORD_W'(1);
        end
        default: ;
      endcase
    end
  end

  // request payload capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_op;
      line_q  <= in_addr & ~32'(LINE_BYTES - 1);
      word_q  <= WORD_W'(in_addr >> 2);
      store_q <= in_store;
      sdata_q <= in_sdata;
      strb_q  <= in_strb;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_res || load_fill) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      out_data_q <= res_data;
      out_user_q <= 1'b0;
      out_last_q <= 1'b1;
    end else if (load_fill) begin
      out_data_q <= fill_data;
      out_user_q <= 1'b1;
      out_last_q <= (k_q == WORD_W'(LINE_WORDS - 1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  `MSHR_ASSERT_ALWAYS(a_used_matches_valid, $countones(entry_valid_q) == int'(used_q), "used count out of step with valid entries")
  `MSHR_ASSERT_IMPLIES(a_fill_needs_hold, (state_q == ST_FILL_RD) || (state_q == ST_FILL_OUT), hold_valid_q, "fill run with no line held")
  `MSHR_ASSERT_IMPLIES(a_collect_excl_hold, collecting_q, !hold_valid_q, "collecting while a line is held")

endmodule
